>>> src/triangle_face_normal_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle face normal core
// Clocked checks on aclk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH

// check that is skipped while aresetn is low
`define TFN_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) expr) else $error(msg);

// check that also covers the reset cycles
`define TFN_ASSERT_RST(label, expr, msg) \
    label: assert property (@(posedge aclk) expr) else $error(msg);

`endif

>>> src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Constants and stage types for the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int FRAC_OUT  = 30;   // fraction bits of the result
    localparam int NORM_W    = 62;   // normalized magnitude, top bit at 61
    localparam int HALF_W    = 31;   // split of a normalized magnitude
    localparam int SQ_W      = 124;  // square of one normalized magnitude
    localparam int SUM_W     = 126;  // sum of three squares
    localparam int ROOT_W    = 63;   // length
    localparam int REM_W     = 66;   // square root remainder
    localparam int SQ_STEPS  = 63;   // one root bit per stage
    localparam int NUM_W     = 93;   // m * 2^30 + len/2
    localparam int Q_W       = 31;   // quotient bits before clamping
    localparam int R_W       = 64;   // division remainder
    localparam int DIV_STEPS = 31;   // one quotient bit per stage
    localparam int OUT_W     = 32;
    localparam int LIMIT_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd4295;
    localparam logic [OUT_W-1:0]   ONE_Q30     = 32'h4000_0000;
    localparam logic [Q_W-1:0]     Q_ONE       = 31'h4000_0000;

    // data that rides along the normalizing, square and square root stages
    typedef struct packed {
        logic [2:0][NORM_W-1:0] m;
        logic [2:0]             neg;
        logic                   degen;
    } pay_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        pay_t              pay;
    } sqrt_st_t;

    typedef struct packed {
        logic [R_W-1:0] r;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] q;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0]   lane;
        logic [ROOT_W-1:0] len;
        logic [2:0]        neg;
        logic              degen;
    } div_st_t;

endpackage

>>> src/triangle_face_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal (Q1.30) of a triangle given as three Q8.16 vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one triangle per transfer, nine coordinates in s_tdata.
//   Master channel m_*: one normal per triangle, in the order of arrival;
//   m_tuser flags a degenerate triangle, whose normal is (0, 0, 1.0).
//   Config channel cfg_*: degenerate_limit (length scaled by 2^32); always
//   ready, write it only while no triangle is in flight.
// Pipeline from the s_ transfer to m_tvalid: 10 stages of edges,
//   cross product, magnitude, limit test, leading-one search, normalizing
//   shift and squares; 63 stages of square root, one bit each; one setup
//   stage; 31 stages of division, one quotient bit each for the three
//   components in parallel; and the output register.
// Throughput: one triangle per cycle while the output does not stall.
// Reset: clears all valid bits and the output valid; the limit returns to 4295.
// Stall: while the output waits and the last stage is full the whole pipeline
//   holds and s_tready is low; empty slots still move up, so the block keeps
//   accepting until the last stage is occupied.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_core_assert.svh"

module triangle_face_normal_core #(
    parameter int COORD_WIDTH = 24,
    localparam int IN_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (COORD_WIDTH each), zero fill
    input  logic [IN_W-1:0] s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // normal_x [31:0], normal_y [63:32], normal_z [95:64]
    output logic [95:0]     m_tdata,
    // degenerate [0]
    output logic [0:0]      m_tuser,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int NW   = PW + 1;
    localparam int MW   = PW;
    localparam int MPW  = (MW > 32) ? MW : 33;
    localparam int NCH  = (MW + 7) / 8;
    localparam int TW   = $clog2(NCH * 8 + 1);
    localparam int XW   = MW + tfn_pkg::NORM_W;
    localparam int SQ0  = 10;
    localparam int INIT = SQ0 + tfn_pkg::SQ_STEPS;
    localparam int DV0  = INIT + 1;
    localparam int NSTG = DV0 + tfn_pkg::DIV_STEPS;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic            m_tvalid_reg;
    logic [95:0]     m_tdata_reg;
    logic [0:0]      m_tuser_reg;
    logic [31:0]     limit_reg;
    logic            adv;

    assign adv       = !(m_tvalid_reg && !m_tready && vld_reg[NSTG-1]);
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= tfn_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: edges u = b - a, v = c - a
    // ------------------------------------------------------------------
    logic signed [CW-1:0] crd [0:8];
    logic signed [EW-1:0] u1_reg [0:2];
    logic signed [EW-1:0] v1_reg [0:2];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            crd[i] = s_tdata[i*CW +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                u1_reg[i] <= EW'(crd[3+i]) - EW'(crd[i]);
                v1_reg[i] <= EW'(crd[6+i]) - EW'(crd[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: six products of the cross product
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p2_reg [0:5];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg[0] <= PW'(u1_reg[1]) * PW'(v1_reg[2]);
            p2_reg[1] <= PW'(u1_reg[2]) * PW'(v1_reg[1]);
            p2_reg[2] <= PW'(u1_reg[2]) * PW'(v1_reg[0]);
            p2_reg[3] <= PW'(u1_reg[0]) * PW'(v1_reg[2]);
            p2_reg[4] <= PW'(u1_reg[0]) * PW'(v1_reg[1]);
            p2_reg[5] <= PW'(u1_reg[1]) * PW'(v1_reg[0]);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: components as sign and magnitude
    // ------------------------------------------------------------------
    logic signed [NW-1:0] n3 [0:2];
    logic [MW-1:0]        mag3_reg [0:2];
    logic [2:0]           neg3_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3[i] = NW'(p2_reg[2*i]) - NW'(p2_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= n3[i][NW-1];
                mag3_reg[i] <= n3[i][NW-1] ? MW'(-n3[i]) : MW'(n3[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: largest magnitude, low squares for the limit test
    // ------------------------------------------------------------------
    logic [MW-1:0]  max01;
    logic [MW-1:0]  max4;
    logic [MPW-1:0] maxp4;
    logic [MPW-1:0] magp4 [0:2];
    logic [MW-1:0]  mag4_reg [0:2];
    logic [2:0]     neg4_reg;
    logic [MW-1:0]  max4_reg;
    logic           small4_reg;
    logic [63:0]    sq4_reg [0:2];
    logic [63:0]    lim4_reg;

    always_comb begin
        max01 = (mag3_reg[0] >= mag3_reg[1]) ? mag3_reg[0] : mag3_reg[1];
        max4  = (max01 >= mag3_reg[2]) ? max01 : mag3_reg[2];
        maxp4 = MPW'(max4);
        for (int i = 0; i < 3; i++) begin
            magp4[i] = MPW'(mag3_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag4_reg   <= mag3_reg;
            neg4_reg   <= neg3_reg;
            max4_reg   <= max4;
            small4_reg <= (maxp4[MPW-1:32] == '0);
            lim4_reg   <= 64'(limit_reg) * 64'(limit_reg);
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= 64'(magp4[i][31:0]) * 64'(magp4[i][31:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: limit test; leading one inside each byte of the maximum
    // ------------------------------------------------------------------
    logic [65:0]      sum5;
    logic [NCH*8-1:0] maxc5;
    logic [NCH-1:0]   nz5;
    logic [2:0]       ctop5 [0:NCH-1];
    logic [MW-1:0]    mag5_reg [0:2];
    logic [2:0]       neg5_reg;
    logic             degen5_reg;
    logic [NCH-1:0]   nz5_reg;
    logic [2:0]       ctop5_reg [0:NCH-1];

    always_comb begin
        sum5  = 66'(sq4_reg[0]) + 66'(sq4_reg[1]) + 66'(sq4_reg[2]);
        maxc5 = (NCH*8)'(max4_reg);
        for (int c = 0; c < NCH; c++) begin
            nz5[c]   = 1'b0;
            ctop5[c] = '0;
            for (int b = 0; b < 8; b++) begin
                if (maxc5[c*8+b]) begin
                    nz5[c]   = 1'b1;
                    ctop5[c] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag5_reg   <= mag4_reg;
            neg5_reg   <= neg4_reg;
            degen5_reg <= small4_reg && (sum5 <= 66'(lim4_reg));
            nz5_reg    <= nz5;
            ctop5_reg  <= ctop5;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: position of the leading one
    // ------------------------------------------------------------------
    logic [TW-1:0] top6;
    logic [MW-1:0] mag6_reg [0:2];
    logic [2:0]    neg6_reg;
    logic          degen6_reg;
    logic [TW-1:0] top6_reg;

    always_comb begin
        top6 = '0;
        for (int c = 0; c < NCH; c++) begin
            if (nz5_reg[c]) begin
                top6 = TW'(c * 8) + TW'(ctop5_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag6_reg   <= mag5_reg;
            neg6_reg   <= neg5_reg;
            degen6_reg <= degen5_reg;
            top6_reg   <= top6;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: shift so the leading one sits at bit 61 (right shift truncates)
    // ------------------------------------------------------------------
    logic [TW-1:0]    amt7;
    logic [XW-1:0]    ext7 [0:2];
    tfn_pkg::pay_t    pay7_next;
    tfn_pkg::pay_t    pay7_reg;

    always_comb begin
        amt7 = top6_reg + TW'(1);
        for (int i = 0; i < 3; i++) begin
            ext7[i]        = {mag6_reg[i], {tfn_pkg::NORM_W{1'b0}}} >> amt7;
            pay7_next.m[i] = ext7[i][tfn_pkg::NORM_W-1:0];
        end
        pay7_next.neg   = neg6_reg;
        pay7_next.degen = degen6_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay7_reg <= pay7_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: 31 x 31 partial products of the squares
    // ------------------------------------------------------------------
    localparam int HW = tfn_pkg::HALF_W;
    logic [2*HW-1:0] hh8_reg [0:2];
    logic [2*HW-1:0] hl8_reg [0:2];
    logic [2*HW-1:0] ll8_reg [0:2];
    tfn_pkg::pay_t   pay8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay8_reg <= pay7_reg;
            for (int i = 0; i < 3; i++) begin
                hh8_reg[i] <= (2*HW)'(pay7_reg.m[i][2*HW-1:HW])
                            * (2*HW)'(pay7_reg.m[i][2*HW-1:HW]);
                hl8_reg[i] <= (2*HW)'(pay7_reg.m[i][2*HW-1:HW])
                            * (2*HW)'(pay7_reg.m[i][HW-1:0]);
                ll8_reg[i] <= (2*HW)'(pay7_reg.m[i][HW-1:0])
                            * (2*HW)'(pay7_reg.m[i][HW-1:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 9: square of each component
    // ------------------------------------------------------------------
    logic [tfn_pkg::SQ_W-1:0] sq9_reg [0:2];
    tfn_pkg::pay_t            pay9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay9_reg <= pay8_reg;
            for (int i = 0; i < 3; i++) begin
                sq9_reg[i] <= {hh8_reg[i], {(2*HW){1'b0}}}
                            + tfn_pkg::SQ_W'({hl8_reg[i], {(HW+1){1'b0}}})
                            + tfn_pkg::SQ_W'(ll8_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 10: sum of squares
    // ------------------------------------------------------------------
    logic [tfn_pkg::SUM_W-1:0] sum10_reg;
    tfn_pkg::pay_t             pay10_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay10_reg <= pay9_reg;
            sum10_reg <= tfn_pkg::SUM_W'(sq9_reg[0]) + tfn_pkg::SUM_W'(sq9_reg[1])
                       + tfn_pkg::SUM_W'(sq9_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // square root, one result bit per stage
    // ------------------------------------------------------------------
    tfn_pkg::sqrt_st_t sq_src  [0:tfn_pkg::SQ_STEPS-1];
    tfn_pkg::sqrt_st_t sq_next [0:tfn_pkg::SQ_STEPS-1];
    tfn_pkg::sqrt_st_t sq_reg  [0:tfn_pkg::SQ_STEPS-1];

    always_comb begin
        sq_src[0].rad  = sum10_reg;
        sq_src[0].rem  = '0;
        sq_src[0].root = '0;
        sq_src[0].pay  = pay10_reg;
        for (int k = 1; k < tfn_pkg::SQ_STEPS; k++) begin
            sq_src[k] = sq_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < tfn_pkg::SQ_STEPS; k++) begin
            logic [tfn_pkg::REM_W+1:0]  rem2;
            logic [tfn_pkg::REM_W+1:0]  trial;
            logic                       ge;
            rem2  = {sq_src[k].rem, sq_src[k].rad[tfn_pkg::SUM_W-1 -: 2]};
            trial = (tfn_pkg::REM_W+2)'({sq_src[k].root, 2'b01});
            ge    = (rem2 >= trial);
            sq_next[k].rad  = {sq_src[k].rad[tfn_pkg::SUM_W-3:0], 2'b00};
            sq_next[k].rem  = ge ? tfn_pkg::REM_W'(rem2 - trial) : tfn_pkg::REM_W'(rem2);
            sq_next[k].root = {sq_src[k].root[tfn_pkg::ROOT_W-2:0], ge};
            sq_next[k].pay  = sq_src[k].pay;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < tfn_pkg::SQ_STEPS; k++) begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // division setup: numerator m * 2^30 + len / 2
    // ------------------------------------------------------------------
    tfn_pkg::sqrt_st_t           sq_last;
    logic [tfn_pkg::NUM_W-1:0]   num_i [0:2];
    tfn_pkg::div_st_t            dinit_next;
    tfn_pkg::div_st_t            dinit_reg;

    assign sq_last = sq_reg[tfn_pkg::SQ_STEPS-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_i[i] = tfn_pkg::NUM_W'({sq_last.pay.m[i], {tfn_pkg::FRAC_OUT{1'b0}}})
                     + tfn_pkg::NUM_W'(sq_last.root >> 1);
            dinit_next.lane[i].r  = tfn_pkg::R_W'(num_i[i][tfn_pkg::NUM_W-1:tfn_pkg::Q_W]);
            dinit_next.lane[i].lo = num_i[i][tfn_pkg::Q_W-1:0];
            dinit_next.lane[i].q  = '0;
        end
        dinit_next.len   = sq_last.root;
        dinit_next.neg   = sq_last.pay.neg;
        dinit_next.degen = sq_last.pay.degen;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dinit_reg <= dinit_next;
        end
    end

    // ------------------------------------------------------------------
    // division, one quotient bit per stage for the three components
    // ------------------------------------------------------------------
    tfn_pkg::div_st_t dv_src  [0:tfn_pkg::DIV_STEPS-1];
    tfn_pkg::div_st_t dv_next [0:tfn_pkg::DIV_STEPS-1];
    tfn_pkg::div_st_t dv_reg  [0:tfn_pkg::DIV_STEPS-1];

    always_comb begin
        dv_src[0] = dinit_reg;
        for (int k = 1; k < tfn_pkg::DIV_STEPS; k++) begin
            dv_src[k] = dv_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < tfn_pkg::DIV_STEPS; k++) begin
            dv_next[k] = dv_src[k];
            for (int i = 0; i < 3; i++) begin
                logic [tfn_pkg::R_W:0] r2;
                logic [tfn_pkg::R_W:0] dd;
                logic                  ge;
                r2 = {dv_src[k].lane[i].r, dv_src[k].lane[i].lo[tfn_pkg::Q_W-1]};
                dd = (tfn_pkg::R_W+1)'(dv_src[k].len);
                ge = (r2 >= dd);
                dv_next[k].lane[i].r  = ge ? tfn_pkg::R_W'(r2 - dd) : tfn_pkg::R_W'(r2);
                dv_next[k].lane[i].lo = {dv_src[k].lane[i].lo[tfn_pkg::Q_W-2:0], 1'b0};
                dv_next[k].lane[i].q  = {dv_src[k].lane[i].q[tfn_pkg::Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < tfn_pkg::DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: clamp, sign, degenerate substitution
    // ------------------------------------------------------------------
    tfn_pkg::div_st_t          dv_last;
    logic [tfn_pkg::Q_W-1:0]   qc [0:2];
    logic [tfn_pkg::OUT_W-1:0] comp [0:2];
    logic [95:0]               tdata_next;

    assign dv_last = dv_reg[tfn_pkg::DIV_STEPS-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qc[i]   = (dv_last.lane[i].q > tfn_pkg::Q_ONE) ? tfn_pkg::Q_ONE
                                                           : dv_last.lane[i].q;
            comp[i] = dv_last.neg[i] ? -tfn_pkg::OUT_W'(qc[i]) : tfn_pkg::OUT_W'(qc[i]);
        end
        if (dv_last.degen) begin
            tdata_next = {tfn_pkg::ONE_Q30, 32'd0, 32'd0};
        end else begin
            tdata_next = {comp[2], comp[1], comp[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= dv_last.degen;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `TFN_ASSERT(a_degen_value, (m_tvalid_reg && m_tuser_reg[0]) |-> (m_tdata_reg[31:0] == 32'd0 && m_tdata_reg[63:32] == 32'd0 && m_tdata_reg[95:64] == tfn_pkg::ONE_Q30), "degenerate result is not (0,0,1)")
    `TFN_ASSERT(a_unit_range, m_tvalid_reg |-> ($signed(m_tdata_reg[31:0]) <= $signed(tfn_pkg::ONE_Q30) && $signed(m_tdata_reg[31:0]) >= -$signed(tfn_pkg::ONE_Q30)), "normal_x out of range")
    `TFN_ASSERT(a_root_norm, (vld_reg[INIT-1] && !sq_last.pay.degen) |-> (sq_last.root[tfn_pkg::ROOT_W-1 -: 2] != 2'b00), "length below 2^61 on a normalized triangle")
    `TFN_ASSERT(a_full_stall, (m_tvalid_reg && !m_tready && vld_reg[NSTG-1]) |-> !s_tready, "input taken while the pipeline is blocked")
    `TFN_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule
